### sv/pal_pkg.sv
package pal_pkg;

    typedef enum logic [1:0] {
        OP_DELETE = 2'd0,
        OP_INSERT = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]  op;
        logic [6:0]  position;
        logic [31:0] entry_id;
        logic [63:0] entry_payload;
    } t_pal_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_id;
        logic [63:0] out_payload;
        logic [6:0]  list_length;
    } t_pal_out;

    // One stored record: identifier and payload share a single memory word.
    typedef struct packed {
        logic [31:0] id;
        logic [63:0] payload;
    } t_pal_entry;

endpackage

### sv/pal_store.sv
module pal_store import pal_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  t_pal_entry               i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output t_pal_entry               o_rd_data
);

    t_pal_entry r_mem [DEPTH];
    t_pal_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### sv/positional_array_list_core.sv
// A rejected transaction goes from idle straight to the done state, where its result is
// registered; reads, inserts and deletes pass through the shift and final states first.
// One transaction is worked on at a time, shifting one entry per cycle through the store's
// single ports; the next is taken the cycle after the result is registered.
// Reset (synchronous, active low) empties the list and drops any pending result; the store
// contents are not cleared, since only written slots are ever read.
module positional_array_list_core import pal_pkg::*; #(
    parameter int DEPTH = 64
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_pal_in  i_data,
    output logic     o_valid,
    input  logic     i_stall,
    output t_pal_out o_data
);

    // Index width for the store, count width able to hold DEPTH itself, and a compare
    // width wide enough for both the count and the 7-bit position plus one.
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = ((CW > 7) ? CW : 7) + 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SHIFT = 4'b0010,
        S_FINAL = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state     r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    t_op        r_op, n_op;
    logic [AW-1:0] r_p0, n_p0;
    logic [CW-1:0] r_left, n_left;
    logic [AW-1:0] r_ptr, n_ptr;
    logic       r_first, n_first;
    logic       r_pend, n_pend;
    logic [AW-1:0] r_pend_addr, n_pend_addr;
    logic       r_pend_cap, n_pend_cap;
    t_pal_entry r_new, n_new;
    t_status    r_status, n_status;
    t_pal_entry r_res, n_res;
    logic       r_out_vld, n_out_vld;
    t_pal_out   r_out, n_out;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    t_pal_entry    rd_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_pal_entry    wr_data;

    logic [KW-1:0] pos_k;
    logic [KW-1:0] cnt_k;
    logic          pos_ge1;
    logic          ins_ok;
    logic          get_ok;
    logic          is_full;

    // The record store: one synchronous memory, registered read data.
    pal_store #(
        .DEPTH(DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Position checks against the current length, done in one widened compare domain.
    assign pos_k   = KW'(i_data.position);
    assign cnt_k   = KW'(r_count);
    assign pos_ge1 = (i_data.position != 7'd0);
    assign ins_ok  = pos_ge1 && (pos_k <= (cnt_k + KW'(1)));
    assign get_ok  = pos_ge1 && (pos_k <= cnt_k);
    assign is_full = (r_count == CW'(DEPTH));

    // New transactions are taken only between operations; the result register lets a
    // finished result wait for the consumer while the next transaction is worked on.
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_op        = r_op;
        n_p0        = r_p0;
        n_left      = r_left;
        n_ptr       = r_ptr;
        n_first     = r_first;
        n_pend      = 1'b0;
        n_pend_addr = r_pend_addr;
        n_pend_cap  = r_pend_cap;
        n_new       = r_new;
        n_status    = r_status;
        n_res       = r_res;
        n_out_vld   = r_out_vld;
        n_out       = r_out;
        rd_en       = 1'b0;
        rd_addr     = r_ptr;
        wr_en       = 1'b0;
        wr_addr     = r_p0;
        wr_data     = r_new;

        // The consumer takes the pending result.
        if (r_out_vld && !i_stall) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op        = t_op'(i_data.op);
                    n_p0        = AW'(pos_k - KW'(1));
                    n_new.id      = i_data.entry_id;
                    n_new.payload = i_data.entry_payload;
                    n_res       = '0;
                    n_status    = ST_RANGE;
                    n_first     = 1'b0;
                    n_state     = S_DONE;
                    unique case (t_op'(i_data.op))
                        OP_INSERT: begin
                            if (ins_ok && is_full) begin
                                n_status = ST_FULL;
                            end else if (ins_ok) begin
                                // Move entries count-1 down to p0 up by one slot,
                                // walking from the top so nothing is overwritten early.
                                n_left  = CW'(cnt_k - (pos_k - KW'(1)));
                                n_ptr   = AW'(cnt_k - KW'(1));
                                n_state = S_SHIFT;
                            end
                        end
                        OP_DELETE: begin
                            if (get_ok) begin
                                // The first read returns the removed record; the rest
                                // move entries p0+1 .. count-1 down by one slot.
                                n_left  = CW'(cnt_k - (pos_k - KW'(1)));
                                n_ptr   = AW'(pos_k - KW'(1));
                                n_first = 1'b1;
                                n_state = S_SHIFT;
                            end
                        end
                        OP_READ: begin
                            if (get_ok) begin
                                n_left  = CW'(1);
                                n_ptr   = AW'(pos_k - KW'(1));
                                n_first = 1'b1;
                                n_state = S_SHIFT;
                            end
                        end
                        default: begin
                            n_status = ST_RANGE;
                        end
                    endcase
                end
            end

            S_SHIFT: begin
                // Issue one read per cycle; the word returned in the next cycle is either
                // captured as the result or written back one slot away. The write always
                // lands two slots from the read issued in the same cycle, so the read
                // and write streams never touch the same entry at once.
                if (r_left != '0) begin
                    rd_en       = 1'b1;
                    rd_addr     = r_ptr;
                    n_left      = r_left - CW'(1);
                    n_ptr       = (r_op == OP_INSERT) ? (r_ptr - AW'(1)) : (r_ptr + AW'(1));
                    n_pend      = 1'b1;
                    n_pend_addr = r_ptr;
                    n_pend_cap  = r_first;
                    n_first     = 1'b0;
                end
                if (r_pend) begin
                    if (r_pend_cap) begin
                        n_res = rd_data;
                    end else begin
                        wr_en   = 1'b1;
                        wr_addr = (r_op == OP_INSERT) ? (r_pend_addr + AW'(1))
                                                      : (r_pend_addr - AW'(1));
                        wr_data = rd_data;
                    end
                end
                if ((r_left == '0) && !r_pend) begin
                    n_state = S_FINAL;
                end
            end

            S_FINAL: begin
                n_status = ST_OK;
                if (r_op == OP_INSERT) begin
                    wr_en   = 1'b1;
                    wr_addr = r_p0;
                    wr_data = r_new;
                    n_count = r_count + CW'(1);
                end else if (r_op == OP_DELETE) begin
                    n_count = r_count - CW'(1);
                end
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_out_vld || !i_stall) begin
                    n_out_vld         = 1'b1;
                    n_out.status      = r_status;
                    n_out.out_id      = r_res.id;
                    n_out.out_payload = r_res.payload;
                    n_out.list_length = 7'(r_count);
                    n_state           = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_p0        <= n_p0;
        r_left      <= n_left;
        r_ptr       <= n_ptr;
        r_first     <= n_first;
        r_pend_addr <= n_pend_addr;
        r_pend_cap  <= n_pend_cap;
        r_new       <= n_new;
        r_status    <= n_status;
        r_res       <= n_res;
        r_out       <= n_out;
    end

endmodule

### dv/positional_array_list_core_test.sv
`timescale 1ns / 1ps

import pal_pkg::*;

// Shadow copy of the list. Every accepted request updates it at once, and the
// answer that the block owes for that request is queued in acceptance order.
class list_tracker;
    int          depth;
    t_pal_entry  records[$];
    t_pal_out    owed_answers[$];
    int          error_count;

    function new(int depth_i);
        depth       = depth_i;
        error_count = 0;
    endfunction

    function int occupancy();
        return records.size();
    endfunction

    function void note_request(t_pal_in req);
        t_pal_out   ans;
        t_pal_entry rec;
        int         cnt;
        int         pos;
        ans        = '0;
        ans.status = ST_RANGE;
        cnt        = records.size();
        pos        = req.position;
        case (req.op)
            OP_INSERT: begin
                if (pos >= 1 && pos <= cnt + 1) begin
                    if (cnt >= depth) begin
                        ans.status = ST_FULL;
                    end else begin
                        rec.id      = req.entry_id;
                        rec.payload = req.entry_payload;
                        records.insert(pos - 1, rec);
                        ans.status = ST_OK;
                    end
                end
            end
            OP_DELETE: begin
                if (pos >= 1 && pos <= cnt) begin
                    ans.out_id      = records[pos - 1].id;
                    ans.out_payload = records[pos - 1].payload;
                    records.delete(pos - 1);
                    ans.status = ST_OK;
                end
            end
            OP_READ: begin
                if (pos >= 1 && pos <= cnt) begin
                    ans.out_id      = records[pos - 1].id;
                    ans.out_payload = records[pos - 1].payload;
                    ans.status      = ST_OK;
                end
            end
            default: begin
            end
        endcase
        ans.list_length = 7'(records.size());
        owed_answers.push_back(ans);
    endfunction

    function void report_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endfunction

    function void check_response(t_pal_out got);
        t_pal_out want;
        if (owed_answers.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status=%0d id=%h payload=%h length=%0d",
                     $time, got.status, got.out_id, got.out_payload, got.list_length);
            error_count++;
            return;
        end
        want = owed_answers.pop_front();
        report_field("status", 64'(want.status), 64'(got.status));
        report_field("out_id", 64'(want.out_id), 64'(got.out_id));
        report_field("out_payload", want.out_payload, got.out_payload);
        report_field("list_length", 64'(want.list_length), 64'(got.list_length));
    endfunction
endclass

module positional_array_list_core_test;

    localparam int         DEPTH          = 64;
    // A long receiver hold-off is the longest correct stretch without any
    // transaction, so the watchdog limit sits well above it.
    localparam int         HOLD_CYCLES    = 300;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         PHASE_ITEMS    = 400;
    // The package leaves the fourth op code unnamed; the block must reject it.
    localparam logic [1:0] OP_UNUSED      = 2'd3;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_stall;
    t_pal_in  i_data  = '0;
    logic     o_valid;
    logic     i_stall = 1'b0;
    t_pal_out o_data;

    list_tracker tracker = new(DEPTH);

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int hold_left      = 0;
    int quiet_cycles   = 0;
    // The random generator alternates between growing and shrinking the list
    // so that it reaches both the empty and the full list many times.
    bit growing        = 1'b1;

    positional_array_list_core #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    // 12 ns period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver side. A hold-off request keeps the output stalled for a long
    // stretch, counted here, so that the block fills up and stalls its input
    // while the sender keeps offering. Otherwise it stalls at random.
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Result checking and the watchdog. Values read here are the ones that
    // were present just before the edge, since all drivers use nonblocking
    // assignments.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            tracker.check_response(o_data);
        end
        if (i_rst_n && ((o_valid && !i_stall) || (i_valid && !o_stall))) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic t_pal_in make_req(logic [1:0] op, int pos, logic [31:0] id,
                                         logic [63:0] payload);
        t_pal_in req;
        req.op            = op;
        req.position      = 7'(pos);
        req.entry_id      = id;
        req.entry_payload = payload;
        return req;
    endfunction

    // Offers one transaction, after a random gap, and holds it until the block
    // takes it. The expectation is noted in this process, so the generator
    // always sees the list as it stands after the previous transaction.
    task automatic send_req(input t_pal_in req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= req;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        tracker.note_request(req);
    endtask

    // Mostly well-formed requests with random records; about one in ten has
    // a bad position and a few carry the unused op code.
    function automatic t_pal_in next_random_req();
        t_pal_in     req;
        int          cnt;
        int          roll;
        int          limit;
        logic [1:0]  op;
        logic [31:0] id;
        logic [63:0] payload;
        cnt = tracker.occupancy();
        if (cnt == 0) begin
            growing = 1'b1;
        end else if (cnt >= DEPTH && $urandom_range(99) < 30) begin
            growing = 1'b0;
        end else if ($urandom_range(99) == 0) begin
            growing = !growing;
        end
        roll = $urandom_range(99);
        if (roll < 3) begin
            op = OP_UNUSED;
        end else if (roll < 18) begin
            op = OP_READ;
        end else if (($urandom_range(99) < 75) == growing) begin
            op = OP_INSERT;
        end else begin
            op = OP_DELETE;
        end
        limit = (op == OP_INSERT) ? cnt + 1 : cnt;
        id      = $urandom;
        payload = {$urandom, $urandom};
        if ($urandom_range(19) == 0) begin
            id      = '1;
            payload = '1;
        end
        req = make_req(op, 1, id, payload);
        if ($urandom_range(99) < 10 || limit == 0) begin
            case ($urandom_range(2))
                0:       req.position = 7'd0;
                1:       req.position = 7'(limit + 1);
                default: req.position = 7'($urandom_range(127, limit + 1));
            endcase
        end else begin
            req.position = 7'($urandom_range(limit, 1));
        end
        return req;
    endfunction

    // Sets the idling of both sides away from the clock edge, so the change
    // cannot race the driving processes, and returns on a rising edge.
    task automatic start_phase(input int idle_pct, input int stall_pct, input bit hold);
        @(negedge i_clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        hold_request   = hold;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (tracker.owed_answers.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_random(input int count);
        repeat (count) begin
            send_req(next_random_req());
        end
        drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, on an empty list with no idling.
        // Delete and read on an empty list are out of range.
        send_req(make_req(OP_DELETE, 1, 32'h0, 64'h0));
        send_req(make_req(OP_READ, 1, 32'h0, 64'h0));
        // Insert at position zero and one past the append slot.
        send_req(make_req(OP_INSERT, 0, 32'hDEAD_BEEF, 64'h1));
        send_req(make_req(OP_INSERT, 2, 32'hDEAD_BEEF, 64'h2));
        // Extreme records: all ones, then all zeros appended, then one at the front.
        send_req(make_req(OP_INSERT, 1, '1, '1));
        send_req(make_req(OP_INSERT, 2, '0, '0));
        send_req(make_req(OP_INSERT, 1, 32'h5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5));
        send_req(make_req(OP_INSERT, 127, 32'h1, 64'h1));
        send_req(make_req(OP_READ, 1, 32'h0, 64'h0));
        send_req(make_req(OP_READ, 2, 32'h0, 64'h0));
        send_req(make_req(OP_READ, 3, 32'h0, 64'h0));
        send_req(make_req(OP_READ, 4, 32'h0, 64'h0));
        // Delete at one past the last entry must be rejected.
        send_req(make_req(OP_DELETE, 4, 32'h0, 64'h0));
        send_req(make_req(OP_DELETE, 127, 32'h0, 64'h0));
        // The unused op code changes nothing, even at a valid position.
        send_req(make_req(OP_UNUSED, 1, '1, '1));
        send_req(make_req(OP_UNUSED, 127, 32'h0, 64'h0));
        // Delete from the middle, then read at position zero.
        send_req(make_req(OP_DELETE, 2, 32'h0, 64'h0));
        send_req(make_req(OP_READ, 0, 32'h0, 64'h0));
        // Append, remove the last entry, then empty the list from the front.
        send_req(make_req(OP_INSERT, 3, 32'h1234_5678, 64'h0123_4567_89AB_CDEF));
        send_req(make_req(OP_DELETE, 3, 32'h0, 64'h0));
        send_req(make_req(OP_DELETE, 1, 32'h0, 64'h0));
        send_req(make_req(OP_DELETE, 1, 32'h0, 64'h0));
        send_req(make_req(OP_DELETE, 0, 32'h0, 64'h0));
        drain();

        // Random phases. The first one opens with a long receiver hold-off
        // while the sender keeps offering.
        start_phase(0, 0, 1'b1);
        run_random(PHASE_ITEMS);
        start_phase(81, 0, 1'b0);
        run_random(PHASE_ITEMS);
        start_phase(0, 81, 1'b0);
        run_random(PHASE_ITEMS);
        start_phase(35, 35, 1'b0);
        run_random(PHASE_ITEMS);

        // Give a stray extra result time to show up before the verdict.
        repeat (DEPTH + 10) @(posedge i_clk);
        if (tracker.error_count == 0 && tracker.owed_answers.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
